[rtl/pldw_pkg.sv]
package pldw_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned DEPTH_W     = 8;
  localparam int unsigned RADIUS_W    = 12;
  localparam int unsigned NUM_W       = 32;
  localparam int unsigned FACTOR_W    = 8;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned RGB_W       = 3 * CHAN_W;
  localparam int unsigned COLOR_W     = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LIGHT_X      = 3'd0,
    REG_LIGHT_Y      = 3'd1,
    REG_LIGHT_Z      = 3'd2,
    REG_DEPTH_SPAN   = 3'd3,
    REG_LIGHT_RADIUS = 3'd4,
    REG_DEPTH_MAX    = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] LIGHT_X_RST      = 12'd0;
  localparam logic [CFG_DATA_W-1:0] LIGHT_Y_RST      = 12'd0;
  localparam logic [DEPTH_W-1:0]    LIGHT_Z_RST      = 8'd17;
  localparam logic [DEPTH_W-1:0]    DEPTH_SPAN_RST   = 8'd16;
  localparam logic [RADIUS_W-1:0]   LIGHT_RADIUS_RST = 12'd255;
  localparam logic [DEPTH_W-1:0]    DEPTH_MAX_RST    = 8'd0;

  // Pipeline control handed to each sub-pipeline.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

endpackage

[rtl/pldw_sqrt.sv]
module pldw_sqrt #(
  parameter int unsigned IN_W   = 25,
  parameter int unsigned SIDE_W = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pldw_pkg::pipe_ctrl_t         ctrl,
  input  logic [IN_W-1:0]              value,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         valid_out,
  output logic [(IN_W+1)/2-1:0]        root_out,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int unsigned RW    = (IN_W + 1) / 2;
  localparam int unsigned PAD_W = 2 * RW;
  localparam int unsigned REM_W = RW + 3;

  // One result bit per stage: stage k settles root bit RW-1-k.
  logic [PAD_W-1:0]  v     [0:RW];
  logic [RW-1:0]     root  [0:RW];
  logic [REM_W-1:0]  rem   [0:RW];
  logic [SIDE_W-1:0] side  [0:RW];
  logic              valid [0:RW];

  assign v[0]     = PAD_W'(value);
  assign root[0]  = '0;
  assign rem[0]   = '0;
  assign side[0]  = side_in;
  assign valid[0] = ctrl.valid;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem[k][REM_W-3:0], v[k][PAD_W-1 -: 2]};
    assign trial  = REM_W'({root[k], 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (ctrl.advance) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.advance) begin
        v[k+1]    <= {v[k][PAD_W-3:0], 2'b00};
        root[k+1] <= {root[k][RW-2:0], fits};
        rem[k+1]  <= fits ? rem_sh - trial : rem_sh;
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_out = valid[RW];
  assign root_out  = root[RW];
  assign side_out  = side[RW];

endmodule

[rtl/pldw_div.sv]
module pldw_div #(
  parameter int unsigned SIDE_W = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pldw_pkg::pipe_ctrl_t                  ctrl,
  input  logic [pldw_pkg::NUM_W-1:0]            num,
  input  logic [pldw_pkg::RADIUS_W-1:0]         den,
  input  logic [SIDE_W-1:0]                     side_in,
  output logic                                  valid_out,
  output logic [pldw_pkg::FACTOR_W-1:0]         quot_out,
  output logic [SIDE_W-1:0]                     side_out
);

  localparam int unsigned NW = pldw_pkg::NUM_W;
  localparam int unsigned DW = pldw_pkg::RADIUS_W;
  localparam int unsigned QW = pldw_pkg::FACTOR_W;

  // Restoring division, one quotient bit per stage. Only the low quotient
  // bits are kept. A zero divisor makes every bit one.
  logic [NW-1:0]     n     [0:NW];
  logic [DW-1:0]     rem   [0:NW];
  logic [QW-1:0]     q     [0:NW];
  logic [SIDE_W-1:0] side  [0:NW];
  logic              valid [0:NW];

  assign n[0]     = num;
  assign rem[0]   = '0;
  assign q[0]     = '0;
  assign side[0]  = side_in;
  assign valid[0] = ctrl.valid;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] sh;
    logic [DW:0] diff;
    logic        ge;

    assign sh   = {rem[k], n[k][NW-1]};
    assign diff = sh - {1'b0, den};
    assign ge   = sh >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (ctrl.advance) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.advance) begin
        n[k+1]    <= {n[k][NW-2:0], 1'b0};
        rem[k+1]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
        q[k+1]    <= {q[k][QW-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_out = valid[NW];
  assign quot_out  = q[NW];
  assign side_out  = side[NW];

endmodule

[rtl/point_light_depth_window_shader.sv]
// Channel   Handshake                       Payload
// pixel     pixel_valid / pixel_stall       pixel_x, pixel_y, pixel_color, pixel_depth
// shaded    shaded_valid / shaded_stall     shaded_color
// config    cfg_we                          cfg_index, cfg_data
//
// One pixel enters per cycle unless the output stalls. A word passes through three
// front stages, one square root stage per result bit, one product stage, 32 divider
// stages and the output stage.
// Reset clears the valid bits and loads the register defaults.
// A stalled output word freezes the whole pipeline, and pixel_stall follows.
module point_light_depth_window_shader #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pldw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pldw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [COORD_WIDTH-1:0]            pixel_x,
  input  logic [COORD_WIDTH-1:0]            pixel_y,
  input  logic [pldw_pkg::COLOR_W-1:0]      pixel_color,
  input  logic [pldw_pkg::DEPTH_W-1:0]      pixel_depth,
  output logic                              shaded_valid,
  input  logic                              shaded_stall,
  output logic [pldw_pkg::RGB_W-1:0]        shaded_color
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned SQ_W   = 2 * CW;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned DIST_W = (SUM_W + 1) / 2;
  localparam int unsigned PROD_W = pldw_pkg::DEPTH_W + DIST_W;
  localparam int unsigned RGB_W  = pldw_pkg::RGB_W;
  localparam int unsigned CHAN_W = pldw_pkg::CHAN_W;
  localparam int unsigned SIDE_W = RGB_W + 1;

  logic [pldw_pkg::CFG_DATA_W-1:0] light_x;
  logic [pldw_pkg::CFG_DATA_W-1:0] light_y;
  logic [pldw_pkg::DEPTH_W-1:0]    light_z;
  logic [pldw_pkg::DEPTH_W-1:0]    depth_span;
  logic [pldw_pkg::RADIUS_W-1:0]   light_radius;
  logic [pldw_pkg::DEPTH_W-1:0]    depth_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= pldw_pkg::LIGHT_X_RST;
      light_y      <= pldw_pkg::LIGHT_Y_RST;
      light_z      <= pldw_pkg::LIGHT_Z_RST;
      depth_span   <= pldw_pkg::DEPTH_SPAN_RST;
      light_radius <= pldw_pkg::LIGHT_RADIUS_RST;
      depth_max    <= pldw_pkg::DEPTH_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pldw_pkg::REG_LIGHT_X:      light_x      <= cfg_data;
        pldw_pkg::REG_LIGHT_Y:      light_y      <= cfg_data;
        pldw_pkg::REG_LIGHT_Z:      light_z      <= cfg_data[pldw_pkg::DEPTH_W-1:0];
        pldw_pkg::REG_DEPTH_SPAN:   depth_span   <= cfg_data[pldw_pkg::DEPTH_W-1:0];
        pldw_pkg::REG_LIGHT_RADIUS: light_radius <= cfg_data;
        pldw_pkg::REG_DEPTH_MAX:    depth_max    <= cfg_data[pldw_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  assign advance     = !(shaded_valid && shaded_stall);
  assign pixel_stall = !advance;

  // Front stage: distances along each axis and the depth window test.
  logic [CW-1:0] lx;
  logic [CW-1:0] ly;
  logic [pldw_pkg::DEPTH_W:0] z_top;
  logic win_hit;

  assign lx      = CW'(light_x);
  assign ly      = CW'(light_y);
  assign z_top   = {1'b0, light_z} + {1'b0, depth_span};
  assign win_hit = (pixel_depth >= light_z) && ({1'b0, pixel_depth} <= z_top);

  logic             s0_valid;
  logic [CW-1:0]    s0_dx;
  logic [CW-1:0]    s0_dy;
  logic [RGB_W-1:0] s0_rgb;
  logic             s0_win;
  logic             s1_valid;
  logic [SQ_W-1:0]  s1_sqx;
  logic [SQ_W-1:0]  s1_sqy;
  logic [RGB_W-1:0] s1_rgb;
  logic             s1_win;
  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum;
  logic [RGB_W-1:0] s2_rgb;
  logic             s2_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= pixel_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_dx  <= (pixel_x >= lx) ? pixel_x - lx : lx - pixel_x;
      s0_dy  <= (pixel_y >= ly) ? pixel_y - ly : ly - pixel_y;
      s0_rgb <= pixel_color[RGB_W-1:0];
      s0_win <= win_hit;
      s1_sqx <= SQ_W'(s0_dx) * SQ_W'(s0_dx);
      s1_sqy <= SQ_W'(s0_dy) * SQ_W'(s0_dy);
      s1_rgb <= s0_rgb;
      s1_win <= s0_win;
      s2_sum <= SUM_W'(s1_sqx) + SUM_W'(s1_sqy);
      s2_rgb <= s1_rgb;
      s2_win <= s1_win;
    end
  end

  pldw_pkg::pipe_ctrl_t sqrt_ctrl;
  logic                 sq_valid;
  logic [DIST_W-1:0]    sq_dist;
  logic [SIDE_W-1:0]    sq_side;

  assign sqrt_ctrl = '{advance: advance, valid: s2_valid};

  pldw_sqrt #(
    .IN_W   (SUM_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sqrt_ctrl),
    .value     (s2_sum),
    .side_in   ({s2_rgb, s2_win}),
    .valid_out (sq_valid),
    .root_out  (sq_dist),
    .side_out  (sq_side)
  );

  // Product stage: brightness numerator term and the final lit decision.
  logic              s3_valid;
  logic [PROD_W-1:0] s3_prod;
  logic [RGB_W-1:0]  s3_rgb;
  logic              s3_lit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_prod <= PROD_W'(depth_max) * PROD_W'(sq_dist);
      s3_rgb  <= sq_side[SIDE_W-1:1];
      s3_lit  <= sq_side[0] && (32'(sq_dist) <= 32'(light_radius));
    end
  end

  pldw_pkg::pipe_ctrl_t            div_ctrl;
  logic [pldw_pkg::NUM_W-1:0]      div_num;
  logic                            dv_valid;
  logic [pldw_pkg::FACTOR_W-1:0]   dv_factor;
  logic [SIDE_W-1:0]               dv_side;

  assign div_ctrl = '{advance: advance, valid: s3_valid};
  assign div_num  = pldw_pkg::NUM_W'(0) - pldw_pkg::NUM_W'(s3_prod);

  pldw_div #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .num       (div_num),
    .den       (light_radius),
    .side_in   ({s3_rgb, s3_lit}),
    .valid_out (dv_valid),
    .quot_out  (dv_factor),
    .side_out  (dv_side)
  );

  // Output stage: each channel times the factor, upper byte kept; unlit pixels give zero.
  logic [2*CHAN_W-1:0] red_p;
  logic [2*CHAN_W-1:0] green_p;
  logic [2*CHAN_W-1:0] blue_p;

  assign red_p   = dv_side[RGB_W:2*CHAN_W+1] * dv_factor;
  assign green_p = dv_side[2*CHAN_W:CHAN_W+1] * dv_factor;
  assign blue_p  = dv_side[CHAN_W:1] * dv_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      shaded_valid <= 1'b0;
    end else if (advance) begin
      shaded_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shaded_color <= dv_side[0]
        ? {red_p[2*CHAN_W-1:CHAN_W], green_p[2*CHAN_W-1:CHAN_W], blue_p[2*CHAN_W-1:CHAN_W]}
        : '0;
    end
  end

endmodule
